// File: hdl/ifb_pkg.sv
// Package with command codes and shared types for the framebuffer blitter.
`default_nettype none
package ifb_pkg;
	typedef enum logic [2:0] {
		CMD_CLEAR   = 3'd0,
		CMD_FILL    = 3'd1,
		CMD_ROUND   = 3'd2,
		CMD_GLYPH   = 3'd3,
		CMD_SETPIX  = 3'd4,
		CMD_READPIX = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		REG_CLIP_LEFT   = 2'd0,
		REG_CLIP_TOP    = 2'd1,
		REG_CLIP_WIDTH  = 2'd2,
		REG_CLIP_HEIGHT = 2'd3
	} reg_idx_t;

	localparam int CFG_IDX_W = 3;
	localparam int COORD_W = 18;
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
endpackage
`default_nettype wire

// File: hdl/indexed_framebuffer_blitter_top.sv
// Top level of the indexed framebuffer blitter.
// Usage: each accepted input word (in_valid high, in_stall low) runs one
// command against the 8-bit frame store; exactly one output word follows
// with pixel_value, which is the read pixel for read pixel and 0 otherwise.
// The block works on one command at a time and lowers in_stall again once
// the previous result has left the output register.
// Each command runs a setup state, then its work (drawing the clipped area,
// with a round rectangle's corners after it, or reading one pixel), and a done
// state posts the result; a clipped glyph first steps through each hidden
// column and row. The single write port of the frame memory sets the rate of
// one pixel per cycle.
// Configuration words on cfg_valid/cfg_ready write the clip registers; the user
// must see that they are only issued while the block is idle, which the block
// does not enforce, and cfg_ready is always high.
// Reset sets the clip rectangle to 320x240 (the full screen only at the default
// size) and empties the pipeline; frame contents are undefined until the first clear.
// When out_stall is high the result word holds in the output register.
`default_nettype none
module indexed_framebuffer_blitter_top
	import ifb_pkg::*;
#(
	parameter int SCREEN_WIDTH = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [2:0]           cmd,
	input  wire logic signed [15:0]   pos_x,
	input  wire logic signed [15:0]   pos_y,
	input  wire logic signed [15:0]   size_w,
	input  wire logic signed [15:0]   size_h,
	input  wire logic [7:0]           color,
	input  wire logic [7:0]           corner_color,
	input  wire logic [7:0]           radius,
	input  wire logic [34:0]          glyph_bits,
	input  wire logic [7:0]           scale,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                pixel_value,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);
	localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SETUP, ST_DRAW, ST_CORNER, ST_READ, ST_DONE
	} state_t;

	state_t state_q;
	logic signed [15:0] clip_left_q, clip_top_q;
	logic [14:0] clip_width_q, clip_height_q;

	// Latched command.
	cmd_t cmd_q;
	logic signed [COORD_W-1:0] px_q, py_q, w_q, h_q;
	logic [7:0] color_q, corner_q, radius_q, scale_q;
	logic [34:0] bits_q;

	// Visible box and scan position.
	logic signed [COORD_W-1:0] vl_q, vt_q, vr_q, vb_q, x_q, y_q;
	logic [AW-1:0] addr_q, row_addr_q;
	// Glyph sub-pixel counters: column and row cell and offset inside cell.
	logic [2:0] gx_q, gy_q;
	logic [7:0] sx_q, sy_q;
	logic [2:0] gx0_q;
	logic [7:0] sx0_q;
	logic [1:0] corner_q2;
	logic [7:0] result_q;

	logic signed [COORD_W-1:0] clip_r, clip_b, rr, rb, gl5, gl7;
	logic signed [COORD_W-1:0] nl, nt, nr, nb;
	logic signed [COORD_W-1:0] cx, cy;
	logic [4:0] cur_row;
	logic pix_on, x_last, y_last, mem_we, onscr;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0] mem_wdata, mem_rdata;

	function automatic logic signed [COORD_W-1:0] smax(
		input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b);
		return (a > b) ? a : b;
	endfunction
	function automatic logic signed [COORD_W-1:0] smin(
		input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE) || out_valid;
	assign pixel_value = result_q;

	always_comb begin
		clip_r = COORD_W'(clip_left_q) + COORD_W'({1'b0, clip_width_q});
		clip_b = COORD_W'(clip_top_q) + COORD_W'({1'b0, clip_height_q});
		rr = px_q + w_q;
		rb = py_q + h_q;
		gl5 = px_q + COORD_W'({2'b0, scale_q, 2'b0}) + COORD_W'(scale_q);
		gl7 = py_q + COORD_W'({2'b0, scale_q, 3'b0}) - COORD_W'(scale_q);
		nl = smax(smax(px_q, COORD_W'(clip_left_q)), '0);
		nt = smax(smax(py_q, COORD_W'(clip_top_q)), '0);
		nr = smin(smin((cmd_q == CMD_GLYPH) ? gl5 : rr, clip_r),
			COORD_W'(SCREEN_WIDTH));
		nb = smin(smin((cmd_q == CMD_GLYPH) ? gl7 : rb, clip_b),
			COORD_W'(SCREEN_HEIGHT));
		cur_row = bits_q[5*gy_q +: 5];
		pix_on = (cmd_q != CMD_GLYPH) || cur_row[3'd4 - gx_q];
		x_last = (x_q + 1'b1 == vr_q);
		y_last = (y_q + 1'b1 == vb_q);
		case (corner_q2)
			2'd0: begin cx = px_q; cy = py_q; end
			2'd1: begin cx = rr - 1'b1; cy = py_q; end
			2'd2: begin cx = px_q; cy = rb - 1'b1; end
			default: begin cx = rr - 1'b1; cy = rb - 1'b1; end
		endcase
		onscr = (px_q >= 0) && (py_q >= 0) && (px_q < SCREEN_WIDTH) &&
			(py_q < SCREEN_HEIGHT);
		mem_we = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = color_q;
		mem_raddr = addr_q;
		if (state_q == ST_DRAW) begin
			mem_we = pix_on;
		end else if (state_q == ST_CORNER) begin
			mem_wdata = corner_q;
			mem_we = (cx >= vl_q) && (cy >= vt_q) && (cx < vr_q) && (cy < vb_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			clip_left_q <= '0;
			clip_top_q <= '0;
			clip_width_q <= 15'd320;
			clip_height_q <= 15'd240;
			result_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_IDX_W'(REG_CLIP_LEFT):   clip_left_q <= cfg_data;
					CFG_IDX_W'(REG_CLIP_TOP):    clip_top_q <= cfg_data;
					CFG_IDX_W'(REG_CLIP_WIDTH):  clip_width_q <= cfg_data[14:0];
					CFG_IDX_W'(REG_CLIP_HEIGHT): clip_height_q <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						cmd_q <= cmd_t'(cmd);
						px_q <= COORD_W'(pos_x);
						py_q <= COORD_W'(pos_y);
						w_q <= COORD_W'(size_w);
						h_q <= COORD_W'(size_h);
						color_q <= color;
						corner_q <= corner_color;
						radius_q <= radius;
						bits_q <= glyph_bits;
						scale_q <= scale;
						result_q <= '0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					corner_q2 <= '0;
					gx_q <= '0; gy_q <= '0; sx_q <= '0; sy_q <= '0;
					gx0_q <= '0; sx0_q <= '0;
					case (cmd_q)
						CMD_CLEAR: begin
							vl_q <= '0; vt_q <= '0;
							vr_q <= COORD_W'(SCREEN_WIDTH);
							vb_q <= COORD_W'(SCREEN_HEIGHT);
							x_q <= '0; y_q <= '0;
							addr_q <= '0; row_addr_q <= '0;
							state_q <= ST_DRAW;
						end
						CMD_FILL, CMD_ROUND, CMD_GLYPH: begin
							// Glyph start offsets inside a cell are computed
							// incrementally, so the scan starts at the glyph
							// origin, not the visible corner; clipped glyphs prestep below.
							// Rectangles start right at the visible corner.
							vl_q <= nl; vt_q <= nt; vr_q <= nr; vb_q <= nb;
							x_q <= (cmd_q == CMD_GLYPH) ? px_q : nl;
							y_q <= (cmd_q == CMD_GLYPH) ? py_q : nt;
							if (nr <= nl || nb <= nt ||
								(cmd_q == CMD_GLYPH && scale_q == '0)) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_READ;
							end
						end
						CMD_SETPIX, CMD_READPIX: begin
							addr_q <= AW'(py_q * SCREEN_WIDTH + px_q);
							if (!onscr) begin
								state_q <= ST_DONE;
							end else if (cmd_q == CMD_SETPIX) begin
								vl_q <= px_q; vt_q <= py_q;
								vr_q <= px_q + 1'b1; vb_q <= py_q + 1'b1;
								x_q <= px_q; y_q <= py_q;
								state_q <= ST_DRAW;
							end else begin
								x_q <= '0;
								state_q <= ST_READ;
							end
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_READ: begin
					if (cmd_q == CMD_READPIX) begin
						// Read data comes from the registered read port, so it is valid in the cycle after the address.
						if (x_q == COORD_W'(1)) begin
							result_q <= mem_rdata;
							state_q <= ST_DONE;
						end
						x_q <= COORD_W'(1);
					end else begin
						// Prestep from the glyph origin to the visible corner,
						// one pixel a step, tracking cell and offset.
						if (x_q < vl_q) begin
							x_q <= x_q + 1'b1;
							if (sx_q + 1'b1 == scale_q) begin
								sx_q <= '0; gx_q <= gx_q + 1'b1;
							end else begin
								sx_q <= sx_q + 1'b1;
							end
						end else if (y_q < vt_q) begin
							y_q <= y_q + 1'b1;
							if (sy_q + 1'b1 == scale_q) begin
								sy_q <= '0; gy_q <= gy_q + 1'b1;
							end else begin
								sy_q <= sy_q + 1'b1;
							end
						end else begin
							gx0_q <= gx_q; sx0_q <= sx_q;
							addr_q <= AW'(vt_q * SCREEN_WIDTH + vl_q);
							row_addr_q <= AW'(vt_q * SCREEN_WIDTH + vl_q);
							state_q <= ST_DRAW;
						end
					end
				end
				ST_DRAW: begin
					if (x_last) begin
						x_q <= vl_q;
						gx_q <= gx0_q; sx_q <= sx0_q;
						addr_q <= row_addr_q + AW'(SCREEN_WIDTH);
						row_addr_q <= row_addr_q + AW'(SCREEN_WIDTH);
						if (sy_q + 1'b1 == scale_q) begin
							sy_q <= '0; gy_q <= gy_q + 1'b1;
						end else begin
							sy_q <= sy_q + 1'b1;
						end
						y_q <= y_q + 1'b1;
						if (y_last) begin
							if (cmd_q == CMD_ROUND && radius_q != '0 &&
								w_q >= 3 && h_q >= 3) begin
								state_q <= ST_CORNER;
								addr_q <= AW'(py_q * SCREEN_WIDTH + px_q);
							end else begin
								state_q <= ST_DONE;
							end
						end
					end else begin
						x_q <= x_q + 1'b1;
						addr_q <= addr_q + 1'b1;
						if (sx_q + 1'b1 == scale_q) begin
							sx_q <= '0; gx_q <= gx_q + 1'b1;
						end else begin
							sx_q <= sx_q + 1'b1;
						end
					end
				end
				ST_CORNER: begin
					corner_q2 <= corner_q2 + 1'b1;
					case (corner_q2)
						2'd0: addr_q <= AW'(py_q * SCREEN_WIDTH + rr - 1'b1);
						2'd1: addr_q <= AW'((rb - 1'b1) * SCREEN_WIDTH + px_q);
						2'd2: addr_q <= AW'((rb - 1'b1) * SCREEN_WIDTH + rr - 1'b1);
						default: state_q <= ST_DONE;
					endcase
				end
				ST_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ifb_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input accepted while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pixel_value)))
		else $error("stalled result changed");
	a_write_only_drawing: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_DRAW || state_q == ST_CORNER))
		else $error("frame write outside drawing");
endmodule
`default_nettype wire

// File: hdl/ifb_frame_mem.sv
// Frame store memory: one write port and one registered read port.
`default_nettype none
module ifb_frame_mem #(
	parameter int DEPTH = 76800,
	parameter int AW = 17
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
